// File: hdl/qapm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_pkg: shared types and constants
// Fixed-point constants, gain bundle, sequencer steps and saturation helper
// for the attitude PID and motor mixer.
// ----------------------------------------------------------------------------
package qapm_pkg;

   localparam int GAIN_W   = 24;
   localparam int CSR_W    = 24;
   localparam int CSR_IDX_W = 3;
   localparam int MA_W     = 34;   // multiplier operand a (errors, states)
   localparam int MB_W     = 25;   // multiplier operand b (gains, constants)
   localparam int PROD_W   = MA_W + MB_W;

   localparam int LOOP_RATE_DEF = 4000;

   // Q16.16 low-pass coefficients: 0.958 and 0.015 * 938.719727597
   localparam int COEF_A = 62783;
   localparam int COEF_B = 922799;

   localparam int MOTOR_OFFSET   = 8192;
   localparam int MOTOR_FLOOR    = 6400;
   localparam int MOTOR_CEIL     = 65535;
   localparam int PULSE_BASE     = 600;
   localparam int PULSE_MAX      = 2714;
   // floor(m / 31) = (m * 67651) >> 21, exact for m < 2^16
   localparam int DIV31_RECIP    = 67651;
   localparam int DIV31_SHIFT    = 21;

   localparam logic [CSR_IDX_W-1:0] REG_ATT_P    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_D   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_DD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_YAW_P    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CLIMB    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FAILSAFE = 3'd5;

   localparam logic [GAIN_W-1:0] RST_ATT_P    = 24'd4352000;
   localparam logic [GAIN_W-1:0] RST_RATE_D   = 24'd640;
   localparam logic [GAIN_W-1:0] RST_RATE_DD  = 24'd3072;
   localparam logic [GAIN_W-1:0] RST_YAW_P    = 24'd205;
   localparam logic [GAIN_W-1:0] RST_CLIMB    = 24'd0;
   localparam logic [15:0]       RST_FAILSAFE = 16'd2000;

   typedef struct packed {
      logic signed [GAIN_W-1:0] att_p;
      logic signed [GAIN_W-1:0] rate_d;
      logic signed [GAIN_W-1:0] rate_dd;
      logic signed [GAIN_W-1:0] yaw_p;
      logic signed [GAIN_W-1:0] climb;
      logic        [15:0]       failsafe;
   } gains_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RA, ST_RB, ST_RF,       // roll filter: state*A, stick*B, feed-forward
      ST_PA, ST_PB, ST_PF,       // pitch filter
      ST_RP, ST_RD, ST_RDD,      // roll P, D, D2
      ST_PP, ST_PD, ST_PDD,      // pitch P, D, D2
      ST_YAW,
      ST_CLIMB,
      ST_MIX,
      ST_MOTOR,
      ST_OUT
   } step_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (x < -64'sd2147483648)
         r = 32'sh80000000;
      else
         r = x[31:0];
      return r;
   endfunction

endpackage

// File: hdl/qapm_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_csr: configuration registers
// Gain and failsafe registers, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module qapm_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [qapm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qapm_pkg::CSR_W-1:0]          csr_wdata,
   output qapm_pkg::gains_type                 gains
);

   qapm_pkg::gains_type gains_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.att_p    <= qapm_pkg::RST_ATT_P;
         gains_ff.rate_d   <= qapm_pkg::RST_RATE_D;
         gains_ff.rate_dd  <= qapm_pkg::RST_RATE_DD;
         gains_ff.yaw_p    <= qapm_pkg::RST_YAW_P;
         gains_ff.climb    <= qapm_pkg::RST_CLIMB;
         gains_ff.failsafe <= qapm_pkg::RST_FAILSAFE;
      end else if (csr_wr_en) begin
         case (csr_index)
            qapm_pkg::REG_ATT_P:    gains_ff.att_p    <= csr_wdata;
            qapm_pkg::REG_RATE_D:   gains_ff.rate_d   <= csr_wdata;
            qapm_pkg::REG_RATE_DD:  gains_ff.rate_dd  <= csr_wdata;
            qapm_pkg::REG_YAW_P:    gains_ff.yaw_p    <= csr_wdata;
            qapm_pkg::REG_CLIMB:    gains_ff.climb    <= csr_wdata;
            qapm_pkg::REG_FAILSAFE: gains_ff.failsafe <= csr_wdata[15:0];
            default: ;   // unmapped index, write dropped
         endcase
      end
   end

   assign gains = gains_ff;

endmodule

// File: hdl/qapm_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qapm_mul: shared multiplier
// Signed 34 x 25 multiply with a registered product, one result per cycle.
// ----------------------------------------------------------------------------
module qapm_mul (
   input  logic                                  clock,
   input  logic signed [qapm_pkg::MA_W-1:0]      op_a,
   input  logic signed [qapm_pkg::MB_W-1:0]      op_b,
   output logic signed [qapm_pkg::PROD_W-1:0]    prod
);

   logic signed [qapm_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= qapm_pkg::PROD_W'(op_a) * qapm_pkg::PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

// File: hdl/quad_attitude_pid_motor_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_attitude_pid_motor_mixer: attitude PID with X motor mixer
// One request word is one control tick; one response word carries four PWM
// widths plus the armed and link-lost flags.
// ----------------------------------------------------------------------------
// Each tick runs through a single shared signed multiplier under a step
// sequencer: two filter products and a feed-forward scale per axis, P/D/D2
// for roll and pitch, yaw P, climb damping, then a divide-by-31 per motor.
// Every multiply step has two phases (operand select, then consume the
// registered product); from accept to the response being loaded a tick runs
// 14 control multiplies, one mix step, four motor multiplies and one output
// step. The multiplier is the limit. req_stall
// is high while a tick is in work; a finished response sits in its own
// register, so the next tick is taken while the response waits. The link
// counter and arm state update at accept; filter and rate error state update
// even while disarmed, and all channels read 600 when disarmed.
// ----------------------------------------------------------------------------
module quad_attitude_pid_motor_mixer #(
   parameter int LOOP_RATE = qapm_pkg::LOOP_RATE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [15:0]                 req_stick_roll,
   input  logic signed [15:0]                 req_stick_pitch,
   input  logic signed [15:0]                 req_stick_yaw,
   input  logic        [11:0]                 req_throttle_cmd,
   input  logic signed [15:0]                 req_att_roll,
   input  logic signed [15:0]                 req_att_pitch,
   input  logic signed [15:0]                 req_rate_x,
   input  logic signed [15:0]                 req_rate_y,
   input  logic signed [15:0]                 req_rate_z,
   input  logic signed [15:0]                 req_climb_rate,
   input  logic                               req_frame_seen,
   input  logic                               req_arm_toggle,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic        [11:0]                 rsp_pulse_ch1,
   output logic        [11:0]                 rsp_pulse_ch2,
   output logic        [11:0]                 rsp_pulse_ch3,
   output logic        [11:0]                 rsp_pulse_ch4,
   output logic                               rsp_armed,
   output logic                               rsp_link_lost,
   // configuration
   input  logic                               csr_wr_en,
   input  logic [qapm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [qapm_pkg::CSR_W-1:0]         csr_wdata
);

   qapm_pkg::gains_type gains;

   // sequencer
   qapm_pkg::step_type step_ff, step_in;
   logic               ph_ff, ph_in;
   logic [1:0]         mcnt_ff;

   // latched tick inputs
   logic signed [15:0] s_roll_ff, s_pitch_ff, s_yaw_ff;
   logic signed [15:0] a_roll_ff, a_pitch_ff;
   logic signed [15:0] gx_ff, gy_ff, gz_ff, climb_ff;
   logic        [11:0] thr_ff;

   // controller state
   logic signed [31:0] filt_r_ff, filt_p_ff, prev_er_ff, prev_ep_ff;
   logic        [15:0] link_ff;
   logic               armed_ff, lost_ff;

   // working registers
   logic signed [63:0] acc_ff;
   logic signed [32:0] diff_ff;
   logic signed [31:0] er_ff, ep_ff;
   logic signed [32:0] ddr_ff, ddp_ff;
   logic signed [63:0] rf_ff, pf_ff, yf_ff, base_ff;
   logic signed [63:0] by_ff, bn_ff, u_ff, v_ff;
   logic        [11:0] pulse_ff [4];

   // response register
   logic               rsp_valid_ff;
   logic        [11:0] rsp_ch_ff [4];
   logic               rsp_armed_ff, rsp_lost_ff;

   // multiplier
   logic signed [qapm_pkg::MA_W-1:0]   op_a;
   logic signed [qapm_pkg::MB_W-1:0]   op_b;
   logic signed [qapm_pkg::PROD_W-1:0] prod;
   logic signed [63:0]                 prod64;

   logic               accept;
   logic [15:0]        lc_base, lc_next;
   logic               lost_next;

   logic signed [17:0] ang_r, ang_p, ang_y;
   logic signed [63:0] lp_sum;
   logic signed [31:0] lp_new;
   logic signed [31:0] ff_val, e_val;
   logic signed [31:0] prev_sel;
   logic signed [18:0] thr_term;
   logic signed [63:0] m_sum, m_shift;
   logic        [15:0] m_val;
   logic               m_first;

   qapm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .gains     (gains)
   );

   qapm_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign prod64    = 64'(prod);
   assign accept    = req_valid && !req_stall;
   assign req_stall = (step_ff != qapm_pkg::ST_IDLE);

   // link counter and arm logic, applied at accept
   assign lc_base   = req_frame_seen ? 16'd0 : link_ff;
   assign lc_next   = (lc_base != 16'hFFFF) ? lc_base + 16'd1 : lc_base;
   assign lost_next = (lc_next > gains.failsafe);

   // angle errors, Q8.8 (scaled to Q16.16 at the multiplier)
   assign ang_r = -18'(a_roll_ff) - 18'(s_roll_ff);
   assign ang_p = 18'(a_pitch_ff) - 18'(s_pitch_ff);
   assign ang_y = -18'(gz_ff) - 18'(s_yaw_ff);

   // low-pass: round half up, floor shift, saturate
   assign lp_sum = acc_ff + (prod64 <<< 8) + 64'sd32768;
   assign lp_new = qapm_pkg::sat32(lp_sum >>> 16);

   // feed-forward and rate error
   assign ff_val   = qapm_pkg::sat32(prod64);
   assign e_val    = (step_ff == qapm_pkg::ST_RF)
                     ? qapm_pkg::sat32((64'(gx_ff) <<< 8) - 64'(ff_val))
                     : qapm_pkg::sat32(-(64'(gy_ff) <<< 8) - 64'(ff_val));
   assign prev_sel = (step_ff == qapm_pkg::ST_RF) ? prev_er_ff : prev_ep_ff;

   // throttle*60 plus mixer offset, integer part of Q.24
   assign thr_term = 19'({thr_ff, 6'b0}) - 19'({thr_ff, 2'b0}) + 19'(qapm_pkg::MOTOR_OFFSET);

   // motor k: ch1 by-u, ch2 bn+v, ch3 bn-v, ch4 by+u
   assign m_first = (mcnt_ff == 2'd0) || (mcnt_ff == 2'd3);
   always_comb begin
      logic signed [63:0] b_sel, t_sel;
      b_sel = m_first ? by_ff : bn_ff;
      t_sel = m_first ? u_ff : v_ff;
      if (mcnt_ff == 2'd1 || mcnt_ff == 2'd3)
         m_sum = b_sel + t_sel;
      else
         m_sum = b_sel - t_sel;
      m_shift = m_sum >>> 24;
      if (m_shift < 64'(qapm_pkg::MOTOR_FLOOR))
         m_val = 16'(qapm_pkg::MOTOR_FLOOR);
      else if (m_shift > 64'(qapm_pkg::MOTOR_CEIL))
         m_val = 16'(qapm_pkg::MOTOR_CEIL);
      else
         m_val = m_shift[15:0];
   end

   // operand select for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (step_ff)
         qapm_pkg::ST_RA: begin
            op_a = qapm_pkg::MA_W'(filt_r_ff);
            op_b = qapm_pkg::MB_W'(qapm_pkg::COEF_A);
         end
         qapm_pkg::ST_RB: begin
            op_a = qapm_pkg::MA_W'(s_roll_ff);
            op_b = qapm_pkg::MB_W'(qapm_pkg::COEF_B);
         end
         qapm_pkg::ST_PA: begin
            op_a = qapm_pkg::MA_W'(filt_p_ff);
            op_b = qapm_pkg::MB_W'(qapm_pkg::COEF_A);
         end
         qapm_pkg::ST_PB: begin
            op_a = qapm_pkg::MA_W'(s_pitch_ff);
            op_b = qapm_pkg::MB_W'(qapm_pkg::COEF_B);
         end
         qapm_pkg::ST_RF, qapm_pkg::ST_PF: begin
            op_a = qapm_pkg::MA_W'(diff_ff);
            op_b = qapm_pkg::MB_W'(LOOP_RATE);
         end
         qapm_pkg::ST_RP: begin
            op_a = qapm_pkg::MA_W'($signed({ang_r, 8'b0}));
            op_b = qapm_pkg::MB_W'(gains.att_p);
         end
         qapm_pkg::ST_PP: begin
            op_a = qapm_pkg::MA_W'($signed({ang_p, 8'b0}));
            op_b = qapm_pkg::MB_W'(gains.att_p);
         end
         qapm_pkg::ST_RD: begin
            op_a = qapm_pkg::MA_W'(er_ff);
            op_b = qapm_pkg::MB_W'(gains.rate_d);
         end
         qapm_pkg::ST_PD: begin
            op_a = qapm_pkg::MA_W'(ep_ff);
            op_b = qapm_pkg::MB_W'(gains.rate_d);
         end
         qapm_pkg::ST_RDD: begin
            op_a = qapm_pkg::MA_W'(ddr_ff);
            op_b = qapm_pkg::MB_W'(gains.rate_dd);
         end
         qapm_pkg::ST_PDD: begin
            op_a = qapm_pkg::MA_W'(ddp_ff);
            op_b = qapm_pkg::MB_W'(gains.rate_dd);
         end
         qapm_pkg::ST_YAW: begin
            op_a = qapm_pkg::MA_W'($signed({ang_y, 8'b0}));
            op_b = qapm_pkg::MB_W'(gains.yaw_p);
         end
         qapm_pkg::ST_CLIMB: begin
            op_a = qapm_pkg::MA_W'(climb_ff);
            op_b = qapm_pkg::MB_W'(gains.climb);
         end
         qapm_pkg::ST_MOTOR: begin
            op_a = qapm_pkg::MA_W'($signed({1'b0, m_val}));
            op_b = qapm_pkg::MB_W'(qapm_pkg::DIV31_RECIP);
         end
         default: ;
      endcase
   end

   // next step: multiply steps take two phases, mix and output one
   always_comb begin
      step_in = step_ff;
      ph_in   = 1'b0;
      unique case (step_ff)
         qapm_pkg::ST_IDLE: if (accept) step_in = qapm_pkg::ST_RA;
         qapm_pkg::ST_MIX:  step_in = qapm_pkg::ST_MOTOR;
         qapm_pkg::ST_OUT:  if (!rsp_valid_ff || !rsp_stall) step_in = qapm_pkg::ST_IDLE;
         qapm_pkg::ST_MOTOR: begin
            ph_in = !ph_ff;
            if (ph_ff && mcnt_ff == 2'd3) step_in = qapm_pkg::ST_OUT;
         end
         default: begin
            ph_in = !ph_ff;
            if (ph_ff) step_in = qapm_pkg::step_type'(step_ff + 5'd1);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= qapm_pkg::ST_IDLE;
         ph_ff   <= 1'b0;
      end else begin
         step_ff <= step_in;
         ph_ff   <= ph_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff      <= '0;
         armed_ff     <= 1'b0;
         lost_ff      <= 1'b0;
         filt_r_ff    <= '0;
         filt_p_ff    <= '0;
         prev_er_ff   <= '0;
         prev_ep_ff   <= '0;
         mcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            link_ff  <= lc_next;
            lost_ff  <= lost_next;
            armed_ff <= (armed_ff ^ req_arm_toggle) & ~lost_next;
            mcnt_ff  <= '0;
         end
         if (ph_ff) begin
            if (step_ff == qapm_pkg::ST_RB) filt_r_ff <= lp_new;
            if (step_ff == qapm_pkg::ST_PB) filt_p_ff <= lp_new;
            if (step_ff == qapm_pkg::ST_RF) prev_er_ff <= e_val;
            if (step_ff == qapm_pkg::ST_PF) prev_ep_ff <= e_val;
            if (step_ff == qapm_pkg::ST_MOTOR) mcnt_ff <= mcnt_ff + 2'd1;
         end
         if (step_ff == qapm_pkg::ST_OUT && (!rsp_valid_ff || !rsp_stall))
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         s_roll_ff  <= req_stick_roll;
         s_pitch_ff <= req_stick_pitch;
         s_yaw_ff   <= req_stick_yaw;
         thr_ff     <= req_throttle_cmd;
         a_roll_ff  <= req_att_roll;
         a_pitch_ff <= req_att_pitch;
         gx_ff      <= req_rate_x;
         gy_ff      <= req_rate_y;
         gz_ff      <= req_rate_z;
         climb_ff   <= req_climb_rate;
      end
      if (ph_ff) begin
         unique case (step_ff)
            qapm_pkg::ST_RA, qapm_pkg::ST_PA,
            qapm_pkg::ST_RP, qapm_pkg::ST_PP: acc_ff <= prod64;
            qapm_pkg::ST_RD, qapm_pkg::ST_PD: acc_ff <= acc_ff + prod64;
            qapm_pkg::ST_RB: diff_ff <= 33'(lp_new) - 33'(filt_r_ff);
            qapm_pkg::ST_PB: diff_ff <= 33'(lp_new) - 33'(filt_p_ff);
            qapm_pkg::ST_RF: begin
               er_ff  <= e_val;
               ddr_ff <= 33'(e_val) - 33'(prev_sel);
            end
            qapm_pkg::ST_PF: begin
               ep_ff  <= e_val;
               ddp_ff <= 33'(e_val) - 33'(prev_sel);
            end
            qapm_pkg::ST_RDD: rf_ff <= acc_ff + prod64;
            qapm_pkg::ST_PDD: pf_ff <= acc_ff + prod64;
            qapm_pkg::ST_YAW: yf_ff <= prod64;
            qapm_pkg::ST_CLIMB:
               base_ff <= (64'(thr_term) <<< 24) - (prod64 <<< 8);
            qapm_pkg::ST_MOTOR:
               pulse_ff[mcnt_ff] <= prod[qapm_pkg::DIV31_SHIFT+11:qapm_pkg::DIV31_SHIFT]
                                    + 12'(qapm_pkg::PULSE_BASE);
            default: ;
         endcase
      end
      if (step_ff == qapm_pkg::ST_MIX) begin
         by_ff <= base_ff + yf_ff;
         bn_ff <= base_ff - yf_ff;
         u_ff  <= rf_ff + pf_ff;
         v_ff  <= rf_ff - pf_ff;
      end
      if (step_ff == qapm_pkg::ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         for (int k = 0; k < 4; k++)
            rsp_ch_ff[k] <= armed_ff ? pulse_ff[k] : 12'(qapm_pkg::PULSE_BASE);
         rsp_armed_ff <= armed_ff;
         rsp_lost_ff  <= lost_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pulse_ch1 = rsp_ch_ff[0];
   assign rsp_pulse_ch2 = rsp_ch_ff[1];
   assign rsp_pulse_ch3 = rsp_ch_ff[2];
   assign rsp_pulse_ch4 = rsp_ch_ff[3];
   assign rsp_armed     = rsp_armed_ff;
   assign rsp_link_lost = rsp_lost_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_disarmed_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_armed |->
         rsp_pulse_ch1 == 12'd600 && rsp_pulse_ch2 == 12'd600 &&
         rsp_pulse_ch3 == 12'd600 && rsp_pulse_ch4 == 12'd600)
      else $error("disarmed response with nonidle pulse");

   a_lost_disarms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_link_lost |-> !rsp_armed)
      else $error("armed while link lost");

   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_pulse_ch1 >= 12'd600 && rsp_pulse_ch1 <= 12'd2714 &&
                    rsp_pulse_ch4 >= 12'd600 && rsp_pulse_ch4 <= 12'd2714)
      else $error("pulse width out of range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sequencer did not start on accept");

endmodule

// File: tb/tb_quad_attitude_pid_motor_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_attitude_pid_motor_mixer: self-checking bench for the PID mixer
// Drives control-tick words with random idle and stall, predicts every
// response word with a bit-exact fixed-point model, compares field by field.
// ----------------------------------------------------------------------------
module tb_quad_attitude_pid_motor_mixer;

   // one control tick as the bench sees it
   typedef struct {
      logic signed [15:0] stick_roll, stick_pitch, stick_yaw;
      logic        [11:0] throttle_cmd;
      logic signed [15:0] att_roll, att_pitch;
      logic signed [15:0] rate_x, rate_y, rate_z;
      logic signed [15:0] climb_rate;
      logic               frame_seen, arm_toggle;
   } tick_type;

   typedef struct {
      logic [11:0] ch1, ch2, ch3, ch4;
      logic        armed, link_lost;
   } pwm_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_stick_roll = '0, req_stick_pitch = '0, req_stick_yaw = '0;
   logic        [11:0] req_throttle_cmd = '0;
   logic signed [15:0] req_att_roll = '0, req_att_pitch = '0;
   logic signed [15:0] req_rate_x = '0, req_rate_y = '0, req_rate_z = '0;
   logic signed [15:0] req_climb_rate = '0;
   logic               req_frame_seen = 1'b0, req_arm_toggle = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [11:0] rsp_pulse_ch1, rsp_pulse_ch2, rsp_pulse_ch3, rsp_pulse_ch4;
   logic        rsp_armed, rsp_link_lost;

   logic                           csr_wr_en = 1'b0;
   logic [qapm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [qapm_pkg::CSR_W-1:0]     csr_wdata = '0;

   quad_attitude_pid_motor_mixer i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_stick_roll(req_stick_roll), .req_stick_pitch(req_stick_pitch),
      .req_stick_yaw(req_stick_yaw), .req_throttle_cmd(req_throttle_cmd),
      .req_att_roll(req_att_roll), .req_att_pitch(req_att_pitch),
      .req_rate_x(req_rate_x), .req_rate_y(req_rate_y), .req_rate_z(req_rate_z),
      .req_climb_rate(req_climb_rate), .req_frame_seen(req_frame_seen),
      .req_arm_toggle(req_arm_toggle),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pulse_ch1(rsp_pulse_ch1), .rsp_pulse_ch2(rsp_pulse_ch2),
      .rsp_pulse_ch3(rsp_pulse_ch3), .rsp_pulse_ch4(rsp_pulse_ch4),
      .rsp_armed(rsp_armed), .rsp_link_lost(rsp_link_lost),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor state: its own copy of gains and controller state
   // ---------------------------------------------------------------------
   logic signed [23:0] m_kp, m_kd, m_kdd, m_kyaw, m_kclimb;
   logic        [15:0] m_failsafe;
   logic signed [31:0] m_filt_r, m_filt_p, m_perr_r, m_perr_p;
   logic        [15:0] m_link_cnt;
   logic               m_armed;

   pwm_type pending_pwm[$];
   int      errors = 0;

   // idle and stall odds in percent, set per phase
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   bit      hold_rsp = 1'b0;

   function automatic longint fl_shift(longint x, int n);
      return x >>> n;   // arithmetic shift on a signed 64-bit value is a floor
   endfunction

   function automatic longint clip32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic logic [11:0] motor_width(longint sum_q24);
      longint m;
      m = fl_shift(sum_q24, 24);
      if (m < qapm_pkg::MOTOR_FLOOR) m = qapm_pkg::MOTOR_FLOOR;
      if (m > qapm_pkg::MOTOR_CEIL) m = qapm_pkg::MOTOR_CEIL;
      return 12'(m / 31 + qapm_pkg::PULSE_BASE);
   endfunction

   task automatic predictor_reset();
      m_kp = qapm_pkg::RST_ATT_P;  m_kd = qapm_pkg::RST_RATE_D;
      m_kdd = qapm_pkg::RST_RATE_DD; m_kyaw = qapm_pkg::RST_YAW_P;
      m_kclimb = qapm_pkg::RST_CLIMB; m_failsafe = qapm_pkg::RST_FAILSAFE;
      m_filt_r = '0; m_filt_p = '0; m_perr_r = '0; m_perr_p = '0;
      m_link_cnt = '0; m_armed = 1'b0;
   endtask

   // one control tick of the predictor
   task automatic predict_tick(input tick_type t);
      longint  sr, sp, sy, ar, ap, gx, gy, gz, cl, kp, kd, kdd, ky, kc;
      longint  old, ffr, ffp, epd, erd, ddp, ddr, pf, rf, yf, base;
      bit      lost;
      pwm_type w;
      sr = t.stick_roll; sp = t.stick_pitch; sy = t.stick_yaw;
      ar = t.att_roll; ap = t.att_pitch;
      gx = t.rate_x; gy = t.rate_y; gz = t.rate_z; cl = t.climb_rate;
      kp = m_kp; kd = m_kd; kdd = m_kdd; ky = m_kyaw; kc = m_kclimb;

      if (t.frame_seen) m_link_cnt = '0;
      if (t.arm_toggle) m_armed = !m_armed;
      if (m_link_cnt != 16'hFFFF) m_link_cnt++;
      lost = m_link_cnt > m_failsafe;
      if (lost) m_armed = 1'b0;

      old = m_filt_r;
      m_filt_r = 32'(clip32(fl_shift(old * qapm_pkg::COEF_A
                                     + sr * qapm_pkg::COEF_B * 256 + 32768, 16)));
      ffr = clip32(longint'(qapm_pkg::LOOP_RATE_DEF) * (longint'(m_filt_r) - old));
      old = m_filt_p;
      m_filt_p = 32'(clip32(fl_shift(old * qapm_pkg::COEF_A
                                     + sp * qapm_pkg::COEF_B * 256 + 32768, 16)));
      ffp = clip32(longint'(qapm_pkg::LOOP_RATE_DEF) * (longint'(m_filt_p) - old));

      epd = clip32(-gy * 256 - ffp);
      ddp = epd - longint'(m_perr_p);
      m_perr_p = 32'(epd);
      pf = kp * ((ap - sp) * 256) + kd * epd + kdd * ddp;

      erd = clip32(gx * 256 - ffr);
      ddr = erd - longint'(m_perr_r);
      m_perr_r = 32'(erd);
      rf = kp * ((-ar - sr) * 256) + kd * erd + kdd * ddr;

      yf = ky * ((-gz - sy) * 256);
      base = longint'(t.throttle_cmd) * 60 * 64'sd16777216 - cl * kc * 256
             + longint'(qapm_pkg::MOTOR_OFFSET) * 64'sd16777216;

      if (m_armed) begin
         w.ch1 = motor_width(base - rf - pf + yf);
         w.ch2 = motor_width(base + rf - pf - yf);
         w.ch3 = motor_width(base - rf + pf - yf);
         w.ch4 = motor_width(base + rf + pf + yf);
      end else begin
         w.ch1 = 12'(qapm_pkg::PULSE_BASE); w.ch2 = 12'(qapm_pkg::PULSE_BASE);
         w.ch3 = 12'(qapm_pkg::PULSE_BASE); w.ch4 = 12'(qapm_pkg::PULSE_BASE);
      end
      w.armed = m_armed;
      w.link_lost = lost;
      pending_pwm.push_back(w);
   endtask

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   // register write at a falling edge, only while the block is idle
   task automatic write_reg(input logic [qapm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [qapm_pkg::CSR_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         qapm_pkg::REG_ATT_P:    m_kp = val;
         qapm_pkg::REG_RATE_D:   m_kd = val;
         qapm_pkg::REG_RATE_DD:  m_kdd = val;
         qapm_pkg::REG_YAW_P:    m_kyaw = val;
         qapm_pkg::REG_CLIMB:    m_kclimb = val;
         qapm_pkg::REG_FAILSAFE: m_failsafe = val[15:0];
         default: ;
      endcase
   endtask

   // send one tick word; returns just after the accepting rising edge,
   // valid is dropped or reloaded at the next falling edge
   task automatic send_tick(input tick_type t);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_stick_roll <= t.stick_roll; req_stick_pitch <= t.stick_pitch;
      req_stick_yaw <= t.stick_yaw; req_throttle_cmd <= t.throttle_cmd;
      req_att_roll <= t.att_roll; req_att_pitch <= t.att_pitch;
      req_rate_x <= t.rate_x; req_rate_y <= t.rate_y; req_rate_z <= t.rate_z;
      req_climb_rate <= t.climb_rate;
      req_frame_seen <= t.frame_seen; req_arm_toggle <= t.arm_toggle;
      do @(posedge clock); while (req_stall);
      predict_tick(t);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pwm.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   function automatic tick_type rand_tick(int mag);
      tick_type t;
      t.stick_roll   = 16'($signed(16'($urandom)) >>> mag);
      t.stick_pitch  = 16'($signed(16'($urandom)) >>> mag);
      t.stick_yaw    = 16'($signed(16'($urandom)) >>> mag);
      t.throttle_cmd = 12'($urandom);
      t.att_roll     = 16'($signed(16'($urandom)) >>> mag);
      t.att_pitch    = 16'($signed(16'($urandom)) >>> mag);
      t.rate_x       = 16'($signed(16'($urandom)) >>> mag);
      t.rate_y       = 16'($signed(16'($urandom)) >>> mag);
      t.rate_z       = 16'($signed(16'($urandom)) >>> mag);
      t.climb_rate   = 16'($signed(16'($urandom)) >>> mag);
      t.frame_seen   = ($urandom_range(99) < 90);
      t.arm_toggle   = ($urandom_range(99) < 8);
      return t;
   endfunction

   // ---------------------------------------------------------------------
   // response checker and receiver stall
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      pwm_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pwm.size() == 0) begin
            $error("response word with nothing expected");
            errors++;
         end else begin
            e = pending_pwm.pop_front();
            if (rsp_pulse_ch1 !== e.ch1) begin
               $error("pulse_ch1 expected %0d got %0d", e.ch1, rsp_pulse_ch1); errors++;
            end
            if (rsp_pulse_ch2 !== e.ch2) begin
               $error("pulse_ch2 expected %0d got %0d", e.ch2, rsp_pulse_ch2); errors++;
            end
            if (rsp_pulse_ch3 !== e.ch3) begin
               $error("pulse_ch3 expected %0d got %0d", e.ch3, rsp_pulse_ch3); errors++;
            end
            if (rsp_pulse_ch4 !== e.ch4) begin
               $error("pulse_ch4 expected %0d got %0d", e.ch4, rsp_pulse_ch4); errors++;
            end
            if (rsp_armed !== e.armed) begin
               $error("armed expected %0d got %0d", e.armed, rsp_armed); errors++;
            end
            if (rsp_link_lost !== e.link_lost) begin
               $error("link_lost expected %0d got %0d", e.link_lost, rsp_link_lost); errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // field extremes, arm toggling, disarmed output, motor overflow and floor
   task automatic test_directed();
      tick_type t;
      t = '{default: '0};
      t.frame_seen = 1'b1;
      send_tick(t);                         // disarmed: all 600
      t.arm_toggle = 1'b1; send_tick(t);    // arm
      t.arm_toggle = 1'b0;
      t.throttle_cmd = 12'hFFF; send_tick(t);   // motor overflow -> 2714
      t.throttle_cmd = 12'h000; send_tick(t);   // zero throttle, mixer offset only
      t.stick_roll = 16'sh7FFF; t.stick_pitch = 16'sh8000; t.stick_yaw = 16'sh7FFF;
      t.att_roll = 16'sh8000; t.att_pitch = 16'sh7FFF;
      t.rate_x = 16'sh7FFF; t.rate_y = 16'sh8000; t.rate_z = 16'sh8000;
      t.climb_rate = 16'sh7FFF; t.throttle_cmd = 12'd2048;
      send_tick(t); send_tick(t);
      t.stick_roll = 16'sh8000; t.stick_pitch = 16'sh7FFF; t.stick_yaw = 16'sh8000;
      t.att_roll = 16'sh7FFF; t.att_pitch = 16'sh8000;
      t.rate_x = 16'sh8000; t.rate_y = 16'sh7FFF; t.rate_z = 16'sh7FFF;
      t.climb_rate = 16'sh8000;
      send_tick(t); send_tick(t);
      t = '{default: '0}; t.frame_seen = 1'b1; t.throttle_cmd = 12'd300;
      t.arm_toggle = 1'b1; send_tick(t);    // disarm, controller still runs
      t.arm_toggle = 1'b0; t.stick_roll = 16'sh0100; send_tick(t);
      wait_drained();
   endtask

   // link counter: loss, arming while lost, recovery
   task automatic test_failsafe();
      tick_type t;
      write_reg(qapm_pkg::REG_FAILSAFE, 24'd3);
      t = '{default: '0}; t.throttle_cmd = 12'd500;
      t.frame_seen = 1'b1; t.arm_toggle = 1'b1; send_tick(t);
      t.frame_seen = 1'b0; t.arm_toggle = 1'b0;
      repeat (4) send_tick(t);              // counter exceeds limit
      t.arm_toggle = 1'b1; send_tick(t);    // arm overridden while lost
      t.frame_seen = 1'b1; send_tick(t);    // recovered and armed
      wait_drained();
      write_reg(qapm_pkg::REG_FAILSAFE, 24'd0);
      t.frame_seen = 1'b0; t.arm_toggle = 1'b0; send_tick(t);
      wait_drained();
   endtask

   // failsafe limit at max: link is never lost
   task automatic test_counter_max();
      tick_type t;
      write_reg(qapm_pkg::REG_FAILSAFE, 24'hFFFF);
      t = '{default: '0}; t.throttle_cmd = 12'd100;
      repeat (3) send_tick(t);
      wait_drained();
   endtask

   // random ticks under one gain setting and one idle and stall setting
   task automatic test_random(input int n, input int idle, input int stall);
      int mag;
      send_idle_pct = idle; stall_pct = stall;
      for (int i = 0; i < n; i++) begin
         mag = ($urandom_range(3) == 0) ? 0 : $urandom_range(9, 4);
         send_tick(rand_tick(mag));
      end
      send_idle_pct = 0; stall_pct = 0;
      wait_drained();
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_backpressure();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         repeat (12) send_tick(rand_tick(6));
      join
      wait_drained();
   endtask

   task automatic set_gains(input logic [23:0] p, d, dd, y, c);
      write_reg(qapm_pkg::REG_ATT_P, p);
      write_reg(qapm_pkg::REG_RATE_D, d);
      write_reg(qapm_pkg::REG_RATE_DD, dd);
      write_reg(qapm_pkg::REG_YAW_P, y);
      write_reg(qapm_pkg::REG_CLIMB, c);
   endtask

   initial begin
      predictor_reset();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      test_directed();
      test_failsafe();
      test_counter_max();
      write_reg(qapm_pkg::REG_FAILSAFE, 24'd20);
      write_reg(3'd7, 24'h123456);          // unmapped index, ignored
      test_random(160, 0, 0);
      set_gains(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
      test_random(80, 77, 0);
      set_gains(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      test_random(60, 0, 77);
      set_gains(24'd1000, 24'hFFFF00, 24'd50, 24'd300, 24'hFFF000);
      test_random(160, 36, 36);
      set_gains(qapm_pkg::RST_ATT_P, qapm_pkg::RST_RATE_D, qapm_pkg::RST_RATE_DD,
                qapm_pkg::RST_YAW_P, 24'd256);
      write_reg(qapm_pkg::REG_FAILSAFE, 24'(qapm_pkg::RST_FAILSAFE));
      test_random(160, 0, 0);
      test_backpressure();

      wait_drained();
      if (errors == 0)
         $display("tb_quad_attitude_pid_motor_mixer passed");
      else
         $display("tb_quad_attitude_pid_motor_mixer failed");
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin
      #20ms;
      $display("tb_quad_attitude_pid_motor_mixer failed");
      $finish;
   end

endmodule

// File: files.f
hdl/qapm_pkg.sv
hdl/qapm_csr.sv
hdl/qapm_mul.sv
hdl/quad_attitude_pid_motor_mixer.sv
tb/tb_quad_attitude_pid_motor_mixer.sv
